FILE: rtl/bsc_pkg.sv
// Shared types, constants and helper functions for the barometric compensation core.
// Used by every module in the rtl folder; depends on nothing else.
package bsc_pkg;

    localparam int DIV_STAGES = 64;

    localparam logic [1:0] REG_TEMP_CAL    = 2'd0;
    localparam logic [1:0] REG_PRESS_CAL_A = 2'd1;
    localparam logic [1:0] REG_PRESS_CAL_B = 2'd2;
    localparam logic [1:0] REG_PRESS_CAL_C = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SKIPPED  = 2'd1;
    localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

    localparam logic [19:0] SKIP_CODE   = 20'h80000;
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] P_FULL      = 64'd1048576;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [63:0] V1_BIAS     = 64'd1 << 47;
    localparam logic [63:0] P_MAX       = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_q24_8;
    } result_t;

    typedef struct packed {
        logic        skip;
        logic        zero;
        logic [19:0] raw_pressure;
        logic [31:0] fine;
    } bsc_tag_t;

    function automatic logic [31:0] sext16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sext16_64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int s);
        return 64'($signed(v) >>> s);
    endfunction

endpackage

FILE: rtl/bsc_mul64.sv
// Two-stage 64 x 64 multiplier keeping the low 64 bits of the product.
// Built from three 32 x 32 partial products; uses bsc_pkg.
module bsc_mul64
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] product
);

    logic [63:0] low_reg;
    logic [31:0] cross_reg;
    logic [63:0] product_reg;
    logic [63:0] low_next;
    logic [31:0] cross_next;

    always_comb
    begin
        low_next   = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        cross_next = (a[31:0] * b[63:32]) + (a[63:32] * b[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            low_reg     <= low_next;
            cross_reg   <= cross_next;
            product_reg <= low_reg + {cross_reg, 32'd0};
        end
    end

    assign product = product_reg;

endmodule

FILE: rtl/bsc_temp.sv
// Three-stage fine temperature pipeline with 32-bit wrapping arithmetic.
// Uses bsc_pkg for the item and tag types.
module bsc_temp
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  sample_t     sample,
    input  logic [47:0] temp_cal,
    output logic        out_valid,
    output bsc_tag_t    tag
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] a_next;
    logic [31:0] b_next;
    logic [2:0]  valid_reg;
    logic [31:0] m1_reg;
    logic [31:0] bb_reg;
    logic [31:0] tv1_reg;
    logic [31:0] m2_reg;
    logic [31:0] fine_reg;
    logic [19:0] rp1_reg;
    logic [19:0] rp2_reg;
    logic [19:0] rp3_reg;
    logic [2:0]  skip_reg;

    always_comb
    begin
        t1     = {16'd0, temp_cal[15:0]};
        t2     = sext16_32(temp_cal[31:16]);
        t3     = sext16_32(temp_cal[47:32]);
        a_next = {15'd0, sample.raw_temperature[19:3]} - (t1 << 1);
        b_next = {16'd0, sample.raw_temperature[19:4]} - t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= a_next * t2;
            bb_reg   <= b_next * b_next;
            tv1_reg  <= asr32(m1_reg, 11);
            m2_reg   <= asr32(bb_reg, 12) * t3;
            fine_reg <= tv1_reg + asr32(m2_reg, 14);
            rp1_reg  <= sample.raw_pressure;
            rp2_reg  <= rp1_reg;
            rp3_reg  <= rp2_reg;
            skip_reg <= {skip_reg[1:0], sample.raw_pressure == SKIP_CODE};
        end
    end

    always_comb
    begin
        tag.skip         = skip_reg[2];
        tag.zero         = 1'b0;
        tag.raw_pressure = rp3_reg;
        tag.fine         = fine_reg;
    end

    assign out_valid = valid_reg[2];

endmodule

FILE: rtl/bsc_sdiv.sv
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
// Uses bsc_pkg for the tag type and the stage count.
module bsc_sdiv
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] numerator,
    input  logic [63:0] denominator,
    input  bsc_tag_t    in_tag,
    output logic        out_valid,
    output logic [63:0] quotient,
    output bsc_tag_t    out_tag
);

    logic [63:0] rem_reg [0:DIV_STAGES];
    logic [63:0] quo_reg [0:DIV_STAGES];
    logic [63:0] den_reg [0:DIV_STAGES];
    logic        neg_reg [0:DIV_STAGES];
    bsc_tag_t    tag_reg [0:DIV_STAGES];
    logic        vld_reg [0:DIV_STAGES];
    logic [63:0] q_reg;
    bsc_tag_t    q_tag_reg;
    logic        q_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            quo_reg[0] <= numerator[63] ? (64'd0 - numerator) : numerator;
            den_reg[0] <= denominator[63] ? (64'd0 - denominator) : denominator;
            neg_reg[0] <= numerator[63] ^ denominator[63];
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        logic [64:0] trial;
        logic        fits;

        always_comb
        begin
            trial = {rem_reg[k], quo_reg[k][63]};
            fits  = trial >= {1'b0, den_reg[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= fits ? 64'(trial - {1'b0, den_reg[k]}) : trial[63:0];
                quo_reg[k+1] <= {quo_reg[k][62:0], fits};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            q_vld_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg     <= neg_reg[DIV_STAGES] ? (64'd0 - quo_reg[DIV_STAGES])
                                             : quo_reg[DIV_STAGES];
            q_tag_reg <= tag_reg[DIV_STAGES];
        end
    end

    assign out_valid = q_vld_reg;
    assign quotient  = q_reg;
    assign out_tag   = q_tag_reg;

endmodule

FILE: rtl/baro_sensor_compensation_core.sv
// Top level of the barometric compensation core: calibration registers and pressure pipeline.
// Depends on bsc_pkg, bsc_mul64, bsc_temp and bsc_sdiv.
//
// Usage: raw pressure and temperature items enter on the sample channel (valid/ready);
// one result item per sample leaves on the result channel (valid/ready) in order.
// The four calibration registers are written through write_enable, reg_index and
// write_data, one register per clock; the user must write them only while no item is
// in flight, and the block itself does not enforce it. From acceptance to result valid
// an item passes the temperature stages, the pressure coefficient stages, the radix-2
// divider (one quotient bit per stage), the final correction and the output register.
// Throughput is one item per cycle outside stalls; the whole pipeline advances together.
// When the receiver stalls with a result waiting, every stage holds and sample_ready
// falls in the same cycle, so no item is lost or repeated.
// Reset clears the calibration registers and all valid bits; the pipeline is empty.
module baro_sensor_compensation_core
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        write_enable,
    input  logic [1:0]  reg_index,
    input  logic [47:0] write_data
);

    logic [47:0] cal_reg [0:3];
    logic        en;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    logic        t_valid;
    bsc_tag_t    t_tag;
    logic [63:0] v1;

    logic [63:0] m_sq, m_p5, m_p2, m_p6, m_p3, m_p1, m_num, m_ph, m_p8, m_p9;

    logic [1:0]  va_reg;
    bsc_tag_t    ta1_reg, ta2_reg;
    logic [1:0]  vb_reg;
    bsc_tag_t    tb1_reg, tb2_reg;
    logic [63:0] b1_reg, b2_reg, c1_reg, c2_reg;
    logic        vc_reg;
    bsc_tag_t    tc_reg;
    logic [63:0] v2_reg, v1x_reg;
    logic [1:0]  vd_reg;
    bsc_tag_t    td1_reg, td2_reg;
    logic [63:0] num_in;
    logic [63:0] den_next;
    bsc_tag_t    div_tag_in;

    logic        q_valid;
    logic [63:0] q;
    bsc_tag_t    q_tag;
    logic [1:0]  vf_reg;
    bsc_tag_t    tf1_reg, tf2_reg;
    logic [63:0] pf1_reg, pf2_reg;
    logic [1:0]  vg_reg;
    bsc_tag_t    tg1_reg, tg2_reg;
    logic [63:0] pg1_reg, pg2_reg, y1_reg, y2_reg;
    logic        vh_reg;
    bsc_tag_t    th_reg;
    logic [63:0] s_reg;
    logic [63:0] p_final;
    result_t     result_next;
    result_t     result_reg;
    logic        result_valid_reg;

    assign en           = !result_valid_reg || result_ready;
    assign sample_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cal_reg[i] <= '0;
            end
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                REG_TEMP_CAL:    cal_reg[0] <= write_data;
                REG_PRESS_CAL_A: cal_reg[1] <= write_data;
                REG_PRESS_CAL_B: cal_reg[2] <= write_data;
                REG_PRESS_CAL_C: cal_reg[3] <= write_data;
                default:         cal_reg[0] <= cal_reg[0];
            endcase
        end
    end

    always_comb
    begin
        p1 = {48'd0, cal_reg[1][15:0]};
        p2 = sext16_64(cal_reg[1][31:16]);
        p3 = sext16_64(cal_reg[1][47:32]);
        p4 = sext16_64(cal_reg[2][15:0]);
        p5 = sext16_64(cal_reg[2][31:16]);
        p6 = sext16_64(cal_reg[2][47:32]);
        p7 = sext16_64(cal_reg[3][15:0]);
        p8 = sext16_64(cal_reg[3][31:16]);
        p9 = sext16_64(cal_reg[3][47:32]);
    end

    bsc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .sample    (sample),
        .temp_cal  (cal_reg[0]),
        .out_valid (t_valid),
        .tag       (t_tag)
    );

    assign v1 = {{32{t_tag.fine[31]}}, t_tag.fine} - FINE_OFFSET;

    bsc_mul64 u_mul_sq (.clk(clk), .en(en), .a(v1), .b(v1), .product(m_sq));
    bsc_mul64 u_mul_p5 (.clk(clk), .en(en), .a(v1), .b(p5), .product(m_p5));
    bsc_mul64 u_mul_p2 (.clk(clk), .en(en), .a(v1), .b(p2), .product(m_p2));

    bsc_mul64 u_mul_p6 (.clk(clk), .en(en), .a(m_sq), .b(p6), .product(m_p6));
    bsc_mul64 u_mul_p3 (.clk(clk), .en(en), .a(m_sq), .b(p3), .product(m_p3));

    assign num_in = ((P_FULL - {44'd0, tc_reg.raw_pressure}) << 31) - v2_reg;

    bsc_mul64 u_mul_p1 (.clk(clk), .en(en), .a(V1_BIAS + v1x_reg), .b(p1),
                        .product(m_p1));
    bsc_mul64 u_mul_num (.clk(clk), .en(en), .a(num_in), .b(P_SCALE),
                         .product(m_num));

    always_comb
    begin
        den_next        = asr64(m_p1, 33);
        div_tag_in      = td2_reg;
        div_tag_in.zero = den_next == 64'd0;
    end

    bsc_sdiv u_sdiv (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (vd_reg[1]),
        .numerator   (m_num),
        .denominator (den_next),
        .in_tag      (div_tag_in),
        .out_valid   (q_valid),
        .quotient    (q),
        .out_tag     (q_tag)
    );

    bsc_mul64 u_mul_ph (.clk(clk), .en(en), .a(asr64(q, 13)), .b(asr64(q, 13)),
                        .product(m_ph));
    bsc_mul64 u_mul_p8 (.clk(clk), .en(en), .a(q), .b(p8), .product(m_p8));
    bsc_mul64 u_mul_p9 (.clk(clk), .en(en), .a(m_ph), .b(p9), .product(m_p9));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg           <= '0;
            vb_reg           <= '0;
            vc_reg           <= 1'b0;
            vd_reg           <= '0;
            vf_reg           <= '0;
            vg_reg           <= '0;
            vh_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg           <= {va_reg[0], t_valid};
            vb_reg           <= {vb_reg[0], va_reg[1]};
            vc_reg           <= vb_reg[1];
            vd_reg           <= {vd_reg[0], vc_reg};
            vf_reg           <= {vf_reg[0], q_valid};
            vg_reg           <= {vg_reg[0], vf_reg[1]};
            vh_reg           <= vg_reg[1];
            result_valid_reg <= vh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta1_reg    <= t_tag;
            ta2_reg    <= ta1_reg;
            tb1_reg    <= ta2_reg;
            tb2_reg    <= tb1_reg;
            b1_reg     <= m_p5;
            b2_reg     <= b1_reg;
            c1_reg     <= m_p2;
            c2_reg     <= c1_reg;
            tc_reg     <= tb2_reg;
            v2_reg     <= m_p6 + (b2_reg << 17) + (p4 << 35);
            v1x_reg    <= asr64(m_p3, 8) + (c2_reg << 12);
            td1_reg    <= tc_reg;
            td2_reg    <= td1_reg;
            tf1_reg    <= q_tag;
            tf2_reg    <= tf1_reg;
            pf1_reg    <= q;
            pf2_reg    <= pf1_reg;
            tg1_reg    <= tf2_reg;
            tg2_reg    <= tg1_reg;
            pg1_reg    <= pf2_reg;
            pg2_reg    <= pg1_reg;
            y1_reg     <= m_p8;
            y2_reg     <= y1_reg;
            th_reg     <= tg2_reg;
            s_reg      <= pg2_reg + asr64(m_p9, 25) + asr64(y2_reg, 19);
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        p_final = asr64(s_reg, 8) + (p7 << 4);
        if (th_reg.skip)
        begin
            result_next.status           = STATUS_SKIPPED;
            result_next.fine_temperature = '0;
            result_next.pressure_q24_8   = '0;
        end
        else if (th_reg.zero)
        begin
            result_next.status           = STATUS_DIV_ZERO;
            result_next.fine_temperature = $signed(th_reg.fine);
            result_next.pressure_q24_8   = '0;
        end
        else
        begin
            result_next.status           = STATUS_OK;
            result_next.fine_temperature = $signed(th_reg.fine);
            if (p_final[63])
            begin
                result_next.pressure_q24_8 = '0;
            end
            else if (p_final > P_MAX)
            begin
                result_next.pressure_q24_8 = '1;
            end
            else
            begin
                result_next.pressure_q24_8 = p_final[31:0];
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_OK || result.status == STATUS_SKIPPED
                          || result.status == STATUS_DIV_ZERO))
        else $error("result status code out of range");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == STATUS_SKIPPED)
        |-> (result.fine_temperature == 0 && result.pressure_q24_8 == 0))
        else $error("skipped item carries non-zero values");

    a_divzero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == STATUS_DIV_ZERO) |-> result.pressure_q24_8 == 0)
        else $error("zero divisor item carries a pressure");

    a_ready_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("waiting result changed during a stall");

endmodule
